// ===== sv/esp_pkg.sv =====
// Package for the exposed surface point counter: sizes, opcodes, store
// record layouts and the sequencer state type. Depends on nothing.
`timescale 1ns / 1ps

package esp_pkg;

  // Store sizes.
  localparam int MAX_SPHERES = 64;
  localparam int MAX_POINTS  = 64;

  localparam int SPH_AW   = $clog2(MAX_SPHERES);
  localparam int PT_AW    = $clog2(MAX_POINTS);
  localparam int PTS_AW   = SPH_AW + PT_AW;
  localparam int PTS_DEPTH = MAX_SPHERES * MAX_POINTS;
  localparam int SCNT_W   = $clog2(MAX_SPHERES + 1);
  localparam int PCNT_W   = $clog2(MAX_POINTS + 1);

  // Field widths of the channel beats.
  localparam int OP_W     = 2;
  localparam int IDX_W    = 6;
  localparam int COORD_W  = 24;
  localparam int RAD_W    = 16;
  localparam int COUNT_W  = 7;
  localparam int UNIT_W   = 16;
  localparam int RESULT_W = 13;

  // Datapath widths: scaled offset, surface point, difference, product.
  localparam int FRAC_SHIFT = 14;
  localparam int SCL_W      = 18;
  localparam int PNT_W      = 25;
  localparam int DIFF_W     = 26;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int SUM_W      = 33;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_SPHERE = 2'd0,
    OP_LOAD_POINT  = 2'd1,
    OP_RUN         = 2'd2,
    OP_NONE        = 2'd3
  } esp_op_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] cz;
    logic        [RAD_W-1:0]   radius;
    logic        [COUNT_W-1:0] npts;
  } sphere_rec_t;

  typedef struct packed {
    logic signed [UNIT_W-1:0] ux;
    logic signed [UNIT_W-1:0] uy;
    logic signed [UNIT_W-1:0] uz;
  } point_rec_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SPH_RD,
    ST_SPH_LAT,
    ST_PT_RD,
    ST_SCL_X,
    ST_SCL_Y,
    ST_SCL_Z,
    ST_SCL_F,
    ST_J_RD,
    ST_SQ_X,
    ST_SQ_Y,
    ST_SQ_Z,
    ST_SQ_R,
    ST_CMP,
    ST_PT_END,
    ST_SPH_END,
    ST_DONE
  } esp_state_t;

endpackage

// ===== sv/esp_in_if.sv =====
// Input channel of the exposed surface point counter: valid, ready and
// the fields of one command beat. Depends on esp_pkg.
`timescale 1ns / 1ps

interface esp_in_if;
  logic                                valid;
  logic                                ready;
  logic [esp_pkg::OP_W-1:0]            op;
  logic [esp_pkg::IDX_W-1:0]           sphere_index;
  logic [esp_pkg::IDX_W-1:0]           point_index;
  logic signed [esp_pkg::COORD_W-1:0]  center_x;
  logic signed [esp_pkg::COORD_W-1:0]  center_y;
  logic signed [esp_pkg::COORD_W-1:0]  center_z;
  logic [esp_pkg::RAD_W-1:0]           radius;
  logic [esp_pkg::COUNT_W-1:0]         point_count;
  logic signed [esp_pkg::UNIT_W-1:0]   unit_x;
  logic signed [esp_pkg::UNIT_W-1:0]   unit_y;
  logic signed [esp_pkg::UNIT_W-1:0]   unit_z;
  logic [esp_pkg::COUNT_W-1:0]         sphere_count;

  modport source (
    output valid, op, sphere_index, point_index, center_x, center_y, center_z,
           radius, point_count, unit_x, unit_y, unit_z, sphere_count,
    input  ready
  );

  modport sink (
    input  valid, op, sphere_index, point_index, center_x, center_y, center_z,
           radius, point_count, unit_x, unit_y, unit_z, sphere_count,
    output ready
  );
endinterface

// ===== sv/esp_out_if.sv =====
// Result channel of the exposed surface point counter: valid, ready and
// the exposed point count. Depends on esp_pkg.
`timescale 1ns / 1ps

interface esp_out_if;
  logic                            valid;
  logic                            ready;
  logic [esp_pkg::RESULT_W-1:0]    exposed_points;

  modport source (
    output valid, exposed_points,
    input  ready
  );

  modport sink (
    input  valid, exposed_points,
    output ready
  );
endinterface

// ===== sv/esp_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered
// read port. Read data holds while no read is enabled. No dependencies.
`timescale 1ns / 1ps

module esp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/exposed_surface_point_count.sv =====
// Exposed surface point counter top level: command decode, sphere and
// point stores, and the sequencer around one shared multiplier.
// Depends on esp_pkg, esp_in_if, esp_out_if and esp_ram.
`timescale 1ns / 1ps

// Usage.
// The input channel carries command beats. A sphere load writes center,
// radius and point count of one sphere; a point load writes one unit
// surface point of one sphere. Both give no result.
// A run beat starts a count over the first sphere_count spheres and gives
// one beat on the result channel with the number of exposed points.
// During a run the input channel is not ready. One 26 x 26 bit multiplier,
// shared by the point scaling, the squared distances and the squared
// radius, sets the run time. Each sphere's record is read, then each of its
// points is scaled and tested against the other spheres in turn, squared
// distances and squared radius through the multiplier, until the first one
// that buries it (or all of them); the sphere's own index is skipped.
// An empty run goes straight to posting its result of zero.
// The result sits in an output register; while the receiver stalls, the
// block returns to accepting loads, and a later run holds its result back
// until the waiting one is taken. Reset clears the sequencer and the
// output valid; the stores keep no reset and must be loaded before a run.
module exposed_surface_point_count (
  input  logic            clk,
  input  logic            rst_n,
  esp_in_if.sink          in_chan,
  esp_out_if.source       out_chan
);

  // Sequencer and loop registers.
  esp_pkg::esp_state_t              state_r, state_nxt;
  logic [esp_pkg::SCNT_W-1:0]       n_r, n_nxt;
  logic [esp_pkg::SPH_AW-1:0]       i_r, i_nxt;
  logic [esp_pkg::SPH_AW-1:0]       j_r, j_nxt;
  logic [esp_pkg::PT_AW-1:0]        k_r, k_nxt;
  logic                             out_valid_r, out_valid_nxt;

  // Datapath registers.
  logic [esp_pkg::RESULT_W-1:0]      exposed_r, exposed_nxt;
  logic [esp_pkg::RESULT_W-1:0]      out_data_r, out_data_nxt;
  logic signed [esp_pkg::COORD_W-1:0] cx_r, cy_r, cz_r;
  logic signed [esp_pkg::COORD_W-1:0] cx_nxt, cy_nxt, cz_nxt;
  logic [esp_pkg::RAD_W-1:0]         rad_r, rad_nxt;
  logic [esp_pkg::PCNT_W-1:0]        np_r, np_nxt;
  logic signed [esp_pkg::PNT_W-1:0]  px_r, py_r, pz_r;
  logic signed [esp_pkg::PNT_W-1:0]  px_nxt, py_nxt, pz_nxt;
  logic signed [esp_pkg::PROD_W-1:0] prod_r;
  logic [esp_pkg::PROD_W-1:0]        acc_r, acc_nxt;

  // Store ports.
  logic                              sph_we, sph_re;
  logic [esp_pkg::SPH_AW-1:0]        sph_raddr;
  esp_pkg::sphere_rec_t              sph_wdata, sph_rdata;
  logic                              pts_we, pts_re;
  esp_pkg::point_rec_t               pts_wdata, pts_rdata;

  // Shared multiplier operands.
  logic signed [esp_pkg::DIFF_W-1:0] mul_a, mul_b;

  // Helper values.
  logic                              in_acc;
  esp_pkg::esp_op_t                  in_op;
  logic                              can_post;
  logic                              j_last, k_last, i_last;
  logic [esp_pkg::PROD_W-1:0]        prod_u;
  logic signed [esp_pkg::SUM_W-1:0]  bias_sum;
  logic signed [esp_pkg::PNT_W-1:0]  scl_ext;
  logic signed [esp_pkg::DIFF_W-1:0] dx, dy, dz;
  logic [esp_pkg::SCNT_W-1:0]        n_clamp;
  logic [esp_pkg::PCNT_W-1:0]        np_clamp;

  assign in_op    = esp_pkg::esp_op_t'(in_chan.op);
  assign in_acc   = in_chan.valid && in_chan.ready;
  assign can_post = !out_valid_r || out_chan.ready;

  // Loop end tests.
  assign j_last = ({1'b0, j_r} + esp_pkg::SCNT_W'(1)) >= n_r;
  assign i_last = ({1'b0, i_r} + esp_pkg::SCNT_W'(1)) >= n_r;
  assign k_last = ({1'b0, k_r} + esp_pkg::PCNT_W'(1)) >= np_r;

  // Count clamps.
  assign n_clamp = (in_chan.sphere_count > esp_pkg::COUNT_W'(esp_pkg::MAX_SPHERES)) ?
                   esp_pkg::SCNT_W'(esp_pkg::MAX_SPHERES) :
                   esp_pkg::SCNT_W'(in_chan.sphere_count);
  assign np_clamp = (sph_rdata.npts > esp_pkg::COUNT_W'(esp_pkg::MAX_POINTS)) ?
                    esp_pkg::PCNT_W'(esp_pkg::MAX_POINTS) :
                    esp_pkg::PCNT_W'(sph_rdata.npts);

  // Rounding of the scaled unit component to 8 fraction bits, ties up.
  assign prod_u   = prod_r;
  assign bias_sum = prod_r[esp_pkg::SUM_W-1:0] + esp_pkg::SUM_W'(1 << (esp_pkg::FRAC_SHIFT - 1));
  assign scl_ext  = esp_pkg::PNT_W'($signed(
                      bias_sum[esp_pkg::FRAC_SHIFT+esp_pkg::SCL_W-1:esp_pkg::FRAC_SHIFT]));

  // Differences between the surface point and the other sphere's center.
  assign dx = esp_pkg::DIFF_W'(px_r) - esp_pkg::DIFF_W'(sph_rdata.cx);
  assign dy = esp_pkg::DIFF_W'(py_r) - esp_pkg::DIFF_W'(sph_rdata.cy);
  assign dz = esp_pkg::DIFF_W'(pz_r) - esp_pkg::DIFF_W'(sph_rdata.cz);

  // Sphere record store.
  assign sph_wdata.cx     = in_chan.center_x;
  assign sph_wdata.cy     = in_chan.center_y;
  assign sph_wdata.cz     = in_chan.center_z;
  assign sph_wdata.radius = in_chan.radius;
  assign sph_wdata.npts   = in_chan.point_count;

  esp_ram #(
    .WIDTH ($bits(esp_pkg::sphere_rec_t)),
    .DEPTH (esp_pkg::MAX_SPHERES)
  ) u_sph_ram (
    .clk   (clk),
    .we    (sph_we),
    .waddr (in_chan.sphere_index[esp_pkg::SPH_AW-1:0]),
    .wdata (sph_wdata),
    .re    (sph_re),
    .raddr (sph_raddr),
    .rdata (sph_rdata)
  );

  // Unit point store, addressed by sphere and slot.
  assign pts_wdata.ux = in_chan.unit_x;
  assign pts_wdata.uy = in_chan.unit_y;
  assign pts_wdata.uz = in_chan.unit_z;

  esp_ram #(
    .WIDTH ($bits(esp_pkg::point_rec_t)),
    .DEPTH (esp_pkg::PTS_DEPTH)
  ) u_pts_ram (
    .clk   (clk),
    .we    (pts_we),
    .waddr ({in_chan.sphere_index[esp_pkg::SPH_AW-1:0],
             in_chan.point_index[esp_pkg::PT_AW-1:0]}),
    .wdata (pts_wdata),
    .re    (pts_re),
    .raddr ({i_r, k_r}),
    .rdata (pts_rdata)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      esp_pkg::ST_IDLE: begin
        if (in_acc && in_op == esp_pkg::OP_RUN) begin
          state_nxt = (n_clamp == '0) ? esp_pkg::ST_DONE : esp_pkg::ST_SPH_RD;
        end
      end
      esp_pkg::ST_SPH_RD:  state_nxt = esp_pkg::ST_SPH_LAT;
      esp_pkg::ST_SPH_LAT: begin
        state_nxt = (np_clamp == '0) ? esp_pkg::ST_SPH_END : esp_pkg::ST_PT_RD;
      end
      esp_pkg::ST_PT_RD:   state_nxt = esp_pkg::ST_SCL_X;
      esp_pkg::ST_SCL_X:   state_nxt = esp_pkg::ST_SCL_Y;
      esp_pkg::ST_SCL_Y:   state_nxt = esp_pkg::ST_SCL_Z;
      esp_pkg::ST_SCL_Z:   state_nxt = esp_pkg::ST_SCL_F;
      esp_pkg::ST_SCL_F:   state_nxt = esp_pkg::ST_J_RD;
      esp_pkg::ST_J_RD: begin
        if (j_r != i_r) begin
          state_nxt = esp_pkg::ST_SQ_X;
        end else if (j_last) begin
          state_nxt = esp_pkg::ST_PT_END;
        end
      end
      esp_pkg::ST_SQ_X:    state_nxt = esp_pkg::ST_SQ_Y;
      esp_pkg::ST_SQ_Y:    state_nxt = esp_pkg::ST_SQ_Z;
      esp_pkg::ST_SQ_Z:    state_nxt = esp_pkg::ST_SQ_R;
      esp_pkg::ST_SQ_R:    state_nxt = esp_pkg::ST_CMP;
      esp_pkg::ST_CMP: begin
        state_nxt = (acc_r < prod_u || j_last) ? esp_pkg::ST_PT_END : esp_pkg::ST_J_RD;
      end
      esp_pkg::ST_PT_END: begin
        state_nxt = k_last ? esp_pkg::ST_SPH_END : esp_pkg::ST_PT_RD;
      end
      esp_pkg::ST_SPH_END: begin
        state_nxt = i_last ? esp_pkg::ST_DONE : esp_pkg::ST_SPH_RD;
      end
      esp_pkg::ST_DONE: begin
        if (can_post) begin
          state_nxt = esp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = esp_pkg::ST_IDLE;
    endcase
  end

  // Control outputs: handshake, store ports and multiplier operands.
  always_comb begin
    in_chan.ready = 1'b0;
    sph_we        = 1'b0;
    pts_we        = 1'b0;
    sph_re        = 1'b0;
    pts_re        = 1'b0;
    sph_raddr     = i_r;
    mul_a         = '0;
    mul_b         = '0;
    unique case (state_r)
      esp_pkg::ST_IDLE: begin
        in_chan.ready = 1'b1;
        sph_we = in_acc && in_op == esp_pkg::OP_LOAD_SPHERE &&
                 ({1'b0, in_chan.sphere_index} < (esp_pkg::IDX_W+1)'(esp_pkg::MAX_SPHERES));
        pts_we = in_acc && in_op == esp_pkg::OP_LOAD_POINT &&
                 ({1'b0, in_chan.sphere_index} < (esp_pkg::IDX_W+1)'(esp_pkg::MAX_SPHERES)) &&
                 ({1'b0, in_chan.point_index} < (esp_pkg::IDX_W+1)'(esp_pkg::MAX_POINTS));
      end
      esp_pkg::ST_SPH_RD: begin
        sph_re    = 1'b1;
        sph_raddr = i_r;
      end
      esp_pkg::ST_PT_RD: begin
        pts_re = 1'b1;
      end
      esp_pkg::ST_SCL_X: begin
        mul_a = esp_pkg::DIFF_W'(pts_rdata.ux);
        mul_b = esp_pkg::DIFF_W'(rad_r);
      end
      esp_pkg::ST_SCL_Y: begin
        mul_a = esp_pkg::DIFF_W'(pts_rdata.uy);
        mul_b = esp_pkg::DIFF_W'(rad_r);
      end
      esp_pkg::ST_SCL_Z: begin
        mul_a = esp_pkg::DIFF_W'(pts_rdata.uz);
        mul_b = esp_pkg::DIFF_W'(rad_r);
      end
      esp_pkg::ST_J_RD: begin
        sph_re    = (j_r != i_r);
        sph_raddr = j_r;
      end
      esp_pkg::ST_SQ_X: begin
        mul_a = dx;
        mul_b = dx;
      end
      esp_pkg::ST_SQ_Y: begin
        mul_a = dy;
        mul_b = dy;
      end
      esp_pkg::ST_SQ_Z: begin
        mul_a = dz;
        mul_b = dz;
      end
      esp_pkg::ST_SQ_R: begin
        mul_a = esp_pkg::DIFF_W'(sph_rdata.radius);
        mul_b = esp_pkg::DIFF_W'(sph_rdata.radius);
      end
      esp_pkg::ST_SPH_LAT, esp_pkg::ST_SCL_F, esp_pkg::ST_CMP, esp_pkg::ST_PT_END,
      esp_pkg::ST_SPH_END, esp_pkg::ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Loop counters, accumulators and the output register.
  always_comb begin
    n_nxt         = n_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    exposed_nxt   = exposed_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    cz_nxt        = cz_r;
    rad_nxt       = rad_r;
    np_nxt        = np_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    pz_nxt        = pz_r;
    acc_nxt       = acc_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    case (state_r)
      esp_pkg::ST_IDLE: begin
        if (in_acc && in_op == esp_pkg::OP_RUN) begin
          n_nxt       = n_clamp;
          i_nxt       = '0;
          exposed_nxt = '0;
        end
      end
      esp_pkg::ST_SPH_LAT: begin
        cx_nxt      = sph_rdata.cx;
        cy_nxt      = sph_rdata.cy;
        cz_nxt      = sph_rdata.cz;
        rad_nxt     = sph_rdata.radius;
        np_nxt      = np_clamp;
        k_nxt       = '0;
        exposed_nxt = exposed_r + esp_pkg::RESULT_W'(np_clamp);
      end
      esp_pkg::ST_SCL_Y: px_nxt = scl_ext + esp_pkg::PNT_W'(cx_r);
      esp_pkg::ST_SCL_Z: py_nxt = scl_ext + esp_pkg::PNT_W'(cy_r);
      esp_pkg::ST_SCL_F: begin
        pz_nxt = scl_ext + esp_pkg::PNT_W'(cz_r);
        j_nxt  = '0;
      end
      esp_pkg::ST_J_RD: begin
        if (j_r == i_r && !j_last) begin
          j_nxt = j_r + esp_pkg::SPH_AW'(1);
        end
      end
      esp_pkg::ST_SQ_Y: acc_nxt = prod_u;
      esp_pkg::ST_SQ_Z: acc_nxt = acc_r + prod_u;
      esp_pkg::ST_SQ_R: acc_nxt = acc_r + prod_u;
      esp_pkg::ST_CMP: begin
        // Strictly inside the other sphere: the point is buried.
        if (acc_r < prod_u) begin
          exposed_nxt = exposed_r - esp_pkg::RESULT_W'(1);
        end else if (!j_last) begin
          j_nxt = j_r + esp_pkg::SPH_AW'(1);
        end
      end
      esp_pkg::ST_PT_END: begin
        if (!k_last) begin
          k_nxt = k_r + esp_pkg::PT_AW'(1);
        end
      end
      esp_pkg::ST_SPH_END: begin
        if (!i_last) begin
          i_nxt = i_r + esp_pkg::SPH_AW'(1);
        end
      end
      esp_pkg::ST_DONE: begin
        if (can_post) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = exposed_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.exposed_points = out_data_r;

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= esp_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath and loop registers; the multiplier output is registered.
  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    k_r        <= k_nxt;
    exposed_r  <= exposed_nxt;
    out_data_r <= out_data_nxt;
    cx_r       <= cx_nxt;
    cy_r       <= cy_nxt;
    cz_r       <= cz_nxt;
    rad_r      <= rad_nxt;
    np_r       <= np_nxt;
    px_r       <= px_nxt;
    py_r       <= py_nxt;
    pz_r       <= pz_nxt;
    acc_r      <= acc_nxt;
    prod_r     <= mul_a * mul_b;
  end

endmodule

// ===== sim/exposed_surface_point_count_checker.sv =====
// Checker for the exposed surface point counter: mirrors the sphere and point
// stores from the command beats, predicts each run's count and compares it.
// Depends on esp_pkg, esp_in_if and esp_out_if.
`timescale 1ns / 1ps

module exposed_surface_point_count_checker
  import esp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  esp_in_if           in_mon,
  esp_out_if          out_mon,
  output int unsigned fail_count,
  output int unsigned pending
);

  localparam int REPORT_LIMIT = 10;

  // Shadow copies of the sphere records and the unit point store.
  logic signed [COORD_W-1:0] sph_cx   [MAX_SPHERES];
  logic signed [COORD_W-1:0] sph_cy   [MAX_SPHERES];
  logic signed [COORD_W-1:0] sph_cz   [MAX_SPHERES];
  logic        [RAD_W-1:0]   sph_rad  [MAX_SPHERES];
  logic        [COUNT_W-1:0] sph_npts [MAX_SPHERES];
  logic signed [UNIT_W-1:0]  unit_x_mem [PTS_DEPTH];
  logic signed [UNIT_W-1:0]  unit_y_mem [PTS_DEPTH];
  logic signed [UNIT_W-1:0]  unit_z_mem [PTS_DEPTH];

  // Counts predicted for accepted runs, oldest first.
  logic [RESULT_W-1:0] exposed_q [$];
  int unsigned mismatches = 0;

  // One coordinate of a surface point: unit times radius, rounded to
  // 8 fraction bits with ties toward plus infinity, then offset by the center.
  function automatic longint surface_coord(logic signed [UNIT_W-1:0] u,
                                           logic [RAD_W-1:0] r,
                                           logic signed [COORD_W-1:0] c);
    longint prod;
    prod = longint'(u) * longint'(r);
    return ((prod + 64'sd8192) >>> FRAC_SHIFT) + longint'(c);
  endfunction

  // Walk the first req spheres and count the points no other sphere buries.
  function automatic logic [RESULT_W-1:0] exposed_count(logic [COUNT_W-1:0] req);
    int          n;
    int          np;
    int          addr;
    longint      px, py, pz;
    longint      dx, dy, dz;
    longint      d2, rr;
    int unsigned total;
    int unsigned buried;
    n = (req > MAX_SPHERES) ? MAX_SPHERES : int'(req);
    total = 0;
    buried = 0;
    for (int i = 0; i < n; i++) begin
      np = (sph_npts[i] > MAX_POINTS) ? MAX_POINTS : int'(sph_npts[i]);
      total += np;
      for (int k = 0; k < np; k++) begin
        addr = i * MAX_POINTS + k;
        px = surface_coord(unit_x_mem[addr], sph_rad[i], sph_cx[i]);
        py = surface_coord(unit_y_mem[addr], sph_rad[i], sph_cy[i]);
        pz = surface_coord(unit_z_mem[addr], sph_rad[i], sph_cz[i]);
        for (int j = 0; j < n; j++) begin
          if (j != i) begin
            dx = px - longint'(sph_cx[j]);
            dy = py - longint'(sph_cy[j]);
            dz = pz - longint'(sph_cz[j]);
            d2 = dx * dx + dy * dy + dz * dz;
            rr = longint'(sph_rad[j]) * longint'(sph_rad[j]);
            // A point is buried once, by the first sphere that holds it.
            if (d2 < rr) begin
              buried++;
              break;
            end
          end
        end
      end
    end
    return RESULT_W'(total - buried);
  endfunction

  // Update the shadow stores on command beats and check result beats.
  always @(posedge clk) begin
    logic [RESULT_W-1:0] want;
    int                  addr;
    if (!rst_n) begin
      pending    <= 0;
      fail_count <= 0;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        case (in_mon.op)
          OP_LOAD_SPHERE: begin
            if (in_mon.sphere_index < MAX_SPHERES) begin
              sph_cx[in_mon.sphere_index]   = in_mon.center_x;
              sph_cy[in_mon.sphere_index]   = in_mon.center_y;
              sph_cz[in_mon.sphere_index]   = in_mon.center_z;
              sph_rad[in_mon.sphere_index]  = in_mon.radius;
              sph_npts[in_mon.sphere_index] = in_mon.point_count;
            end
          end
          OP_LOAD_POINT: begin
            if (in_mon.sphere_index < MAX_SPHERES && in_mon.point_index < MAX_POINTS) begin
              addr = int'(in_mon.sphere_index) * MAX_POINTS + int'(in_mon.point_index);
              unit_x_mem[addr] = in_mon.unit_x;
              unit_y_mem[addr] = in_mon.unit_y;
              unit_z_mem[addr] = in_mon.unit_z;
            end
          end
          OP_RUN: exposed_q.push_back(exposed_count(in_mon.sphere_count));
          default: ;
        endcase
      end

      if (out_mon.valid && out_mon.ready) begin
        if (exposed_q.size() == 0) begin
          if (mismatches < REPORT_LIMIT)
            $display("%0t: result beat with no run pending: exposed_points %0d",
                     $time, out_mon.exposed_points);
          mismatches++;
        end else begin
          want = exposed_q.pop_front();
          if (out_mon.exposed_points !== want) begin
            if (mismatches < REPORT_LIMIT)
              $display("%0t: exposed_points mismatch: expected %0d, got %0d",
                       $time, want, out_mon.exposed_points);
            mismatches++;
          end
        end
      end

      pending    <= exposed_q.size();
      fail_count <= mismatches;
    end
  end

endmodule

// ===== sim/exposed_surface_point_count_tb.sv =====
// Testbench top for the exposed surface point counter: clock, reset, command
// stimulus, result back-pressure, watchdog and verdict.
// Depends on esp_pkg, esp_in_if, esp_out_if, the block and its checker.
`timescale 1ns / 1ps

module exposed_surface_point_count_tb;
  import esp_pkg::*;

  localparam int ITEMS        = 1250;
  // The largest runs here walk about 200 points against 64 spheres
  // with no beat moving; this limit is set well above such a run.
  localparam int IDLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    esp_op_t                   op;
    logic        [IDX_W-1:0]   sidx;
    logic        [IDX_W-1:0]   pidx;
    logic signed [COORD_W-1:0] cx, cy, cz;
    logic        [RAD_W-1:0]   rad;
    logic        [COUNT_W-1:0] npts;
    logic signed [UNIT_W-1:0]  ux, uy, uz;
    logic        [COUNT_W-1:0] scount;
  } esp_cmd_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned idle_cycles = 0;
  int unsigned items_sent = 0;
  bit in_steady = 1'b0;
  bit out_steady = 1'b0;

  // What has been written so far, so that a run never reads an empty entry.
  bit                 sphere_loaded [MAX_SPHERES];
  logic [COUNT_W-1:0] sphere_npts   [MAX_SPHERES];
  bit                 point_loaded  [PTS_DEPTH];

  always #5 clk = ~clk;

  esp_in_if  in_chan ();
  esp_out_if out_chan ();

  exposed_surface_point_count uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  exposed_surface_point_count_checker count_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_chan),
    .out_mon    (out_chan),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Watchdog: cycles in a row with no beat on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("exposed_surface_point_count_tb: FAIL");
        $finish;
      end
    end
  end

  // Result side: random stalls before each beat, with stall-free stretches.
  initial begin
    int unsigned gap;
    out_chan.ready <= 1'b0;
    repeat (7) @(posedge clk);
    forever begin
      if ($urandom_range(0, 29) == 0) out_steady = !out_steady;
      gap = out_steady ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        out_chan.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      @(posedge clk);
      while (!out_chan.valid) @(posedge clk);
    end
  end

  function automatic esp_cmd_t random_cmd(esp_op_t op);
    esp_cmd_t c;
    c.op     = op;
    c.sidx   = IDX_W'($urandom);
    c.pidx   = IDX_W'($urandom);
    c.cx     = COORD_W'($urandom);
    c.cy     = COORD_W'($urandom);
    c.cz     = COORD_W'($urandom);
    c.rad    = RAD_W'($urandom);
    c.npts   = COUNT_W'($urandom);
    c.ux     = UNIT_W'($urandom);
    c.uy     = UNIT_W'($urandom);
    c.uz     = UNIT_W'($urandom);
    c.scount = COUNT_W'($urandom);
    return c;
  endfunction

  // Mostly inside the Q1.14 unit range, now and then any 16-bit value.
  function automatic logic signed [UNIT_W-1:0] rand_unit();
    int v;
    if ($urandom_range(0, 9) == 0) return UNIT_W'($urandom);
    v = int'($urandom_range(0, 32768)) - 16384;
    return UNIT_W'(v);
  endfunction

  function automatic int rand_radius();
    case ($urandom_range(0, 15))
      0:       return 0;
      1:       return 65535;
      2:       return int'($urandom_range(0, 65535));
      default: return int'($urandom_range(128, 4096));
    endcase
  endfunction

  function automatic int rand_npts();
    case ($urandom_range(0, 19))
      0:       return 0;
      1:       return MAX_POINTS;
      2:       return int'($urandom_range(65, 127));
      3:       return int'($urandom_range(7, 20));
      default: return int'($urandom_range(1, 6));
    endcase
  endfunction

  function automatic int jitter(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // Drive one command beat after a random gap and wait until it is taken.
  task automatic send_cmd(esp_cmd_t c);
    int unsigned gap;
    if ($urandom_range(0, 49) == 0) in_steady = !in_steady;
    gap = in_steady ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid        <= 1'b1;
    in_chan.op           <= c.op;
    in_chan.sphere_index <= c.sidx;
    in_chan.point_index  <= c.pidx;
    in_chan.center_x     <= c.cx;
    in_chan.center_y     <= c.cy;
    in_chan.center_z     <= c.cz;
    in_chan.radius       <= c.rad;
    in_chan.point_count  <= c.npts;
    in_chan.unit_x       <= c.ux;
    in_chan.unit_y       <= c.uy;
    in_chan.unit_z       <= c.uz;
    in_chan.sphere_count <= c.scount;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    case (c.op)
      OP_LOAD_SPHERE: begin
        sphere_loaded[c.sidx] = 1'b1;
        sphere_npts[c.sidx]   = c.npts;
      end
      OP_LOAD_POINT: point_loaded[int'(c.sidx) * MAX_POINTS + int'(c.pidx)] = 1'b1;
      default: ;
    endcase
    if (c.op != OP_NONE) items_sent++;
  endtask

  task automatic load_sphere(int idx, int cx, int cy, int cz, int rad, int npts);
    esp_cmd_t c;
    c = random_cmd(OP_LOAD_SPHERE);
    c.sidx = IDX_W'(idx);
    c.cx   = COORD_W'(cx);
    c.cy   = COORD_W'(cy);
    c.cz   = COORD_W'(cz);
    c.rad  = RAD_W'(rad);
    c.npts = COUNT_W'(npts);
    send_cmd(c);
  endtask

  task automatic load_unit(int s, int p, int ux, int uy, int uz);
    esp_cmd_t c;
    c = random_cmd(OP_LOAD_POINT);
    c.sidx = IDX_W'(s);
    c.pidx = IDX_W'(p);
    c.ux   = UNIT_W'(ux);
    c.uy   = UNIT_W'(uy);
    c.uz   = UNIT_W'(uz);
    send_cmd(c);
  endtask

  task automatic load_random_unit(int s, int p);
    load_unit(s, p, int'(rand_unit()), int'(rand_unit()), int'(rand_unit()));
  endtask

  // Fill whatever the run would read but was never written, then start it.
  task automatic start_run(int n);
    int       lim;
    int       np;
    esp_cmd_t c;
    lim = (n > MAX_SPHERES) ? MAX_SPHERES : n;
    for (int i = 0; i < lim; i++)
      if (!sphere_loaded[i])
        load_sphere(i, jitter(20000), jitter(20000), jitter(20000), rand_radius(),
                    int'($urandom_range(0, 3)));
    for (int i = 0; i < lim; i++) begin
      np = (sphere_npts[i] > MAX_POINTS) ? MAX_POINTS : int'(sphere_npts[i]);
      for (int k = 0; k < np; k++)
        if (!point_loaded[i * MAX_POINTS + k]) load_random_unit(i, k);
    end
    c = random_cmd(OP_RUN);
    c.scount = COUNT_W'(n);
    send_cmd(c);
  endtask

  // Hold the command side until every pending count has come back.
  task automatic wait_drained();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // A tight group of spheres around a random base so that points get buried.
  task automatic build_cluster(int n);
    int bx, by, bz;
    if ($urandom_range(0, 7) == 0) begin
      bx = int'($urandom);
      by = int'($urandom);
      bz = int'($urandom);
    end else begin
      bx = jitter(100000);
      by = jitter(100000);
      bz = jitter(100000);
    end
    for (int i = 0; i < n; i++) begin
      load_sphere(i, bx + jitter(8192), by + jitter(8192), bz + jitter(8192),
                  rand_radius(), rand_npts());
      // Now and then overwrite a point slot that is already in use.
      if ($urandom_range(0, 3) == 0)
        load_random_unit($urandom_range(0, n - 1), $urandom_range(0, MAX_POINTS - 1));
    end
  endtask

  // Every sphere in use, most with few points, two with the full list.
  task automatic big_scene(int n);
    int heavy_a, heavy_b, np;
    wait_drained();
    heavy_a = $urandom_range(0, MAX_SPHERES - 1);
    heavy_b = $urandom_range(0, MAX_SPHERES - 1);
    for (int i = 0; i < MAX_SPHERES; i++) begin
      if (i == heavy_a)      np = MAX_POINTS;
      else if (i == heavy_b) np = int'($urandom_range(65, 127));
      else                   np = int'($urandom_range(0, 2));
      load_sphere(i, i * 3000 + jitter(1500), jitter(1500), jitter(1500),
                  int'($urandom_range(256, 3000)), np);
    end
    start_run(n);
  endtask

  initial begin
    int n;
    bit big_done;
    bit huge_done;
    big_done  = 1'b0;
    huge_done = 1'b0;
    in_chan.valid        <= 1'b0;
    in_chan.op           <= OP_NONE;
    in_chan.sphere_index <= '0;
    in_chan.point_index  <= '0;
    in_chan.center_x     <= '0;
    in_chan.center_y     <= '0;
    in_chan.center_z     <= '0;
    in_chan.radius       <= '0;
    in_chan.point_count  <= '0;
    in_chan.unit_x       <= '0;
    in_chan.unit_y       <= '0;
    in_chan.unit_z       <= '0;
    in_chan.sphere_count <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: unused opcode, empty run, field extremes, boundary cases.
    send_cmd(random_cmd(OP_NONE));
    start_run(0);
    load_sphere(0, 8388607, -8388608, 0, 65535, 2);
    load_unit(0, 0, 32767, -32768, 16384);
    load_unit(0, 1, -16384, 16384, -32768);
    load_sphere(1, 8388607 - 10000, -8388608, 0, 65535, 1);
    load_unit(1, 0, 0, 0, 0);
    start_run(1);
    start_run(2);
    // Zero radius and no points.
    load_sphere(2, -8388608, 8388607, -8388608, 0, 0);
    start_run(3);
    // Points exactly on another sphere's surface are not buried.
    load_sphere(3, 0, 0, 0, 256, 1);
    load_unit(3, 0, 16384, 0, 0);
    load_sphere(4, 512, 0, 0, 256, 1);
    load_unit(4, 0, -16384, 0, 0);
    // Rounding ties of the scaled point go toward plus infinity.
    load_sphere(5, 0, 0, 0, 1, 2);
    load_unit(5, 0, 8192, -8192, 0);
    load_unit(5, 1, -8192, 8192, 16384);
    start_run(6);
    start_run(5);
    wait_drained();

    // Random scenes, with two runs over every sphere.
    while (items_sent < ITEMS) begin
      if (!big_done && items_sent >= 400) begin
        big_scene(MAX_SPHERES);
        big_done = 1'b1;
      end else if (!huge_done && items_sent >= 900) begin
        big_scene(int'($urandom_range(MAX_SPHERES + 1, 127)));
        huge_done = 1'b1;
      end else begin
        case ($urandom_range(0, 9))
          0: send_cmd(random_cmd(OP_NONE));
          1: start_run(int'($urandom_range(0, 8)));
          default: begin
            n = int'($urandom_range(2, 6));
            build_cluster(n);
            start_run(n);
            if ($urandom_range(0, 3) == 0) start_run(int'($urandom_range(0, n)));
          end
        endcase
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("exposed_surface_point_count_tb: PASS");
    else
      $display("exposed_surface_point_count_tb: FAIL");
    $finish;
  end

endmodule
